// ----- hdl/sesp_pkg.sv -----
// ----------------------------------------------------------------------------
// sesp_pkg
// Shared types and constants for the signed-envelope stream parser: parse
// stages, byte-string reader phases, verdict codes, byte kinds and the
// per-byte result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sesp_pkg;

  // Framing constants
  localparam logic [7:0] TagByte      = 8'hD2;
  localparam logic [7:0] ArrayByte    = 8'h84;
  localparam logic [7:0] EmptyMapByte = 8'hA0;
  localparam logic [7:0] BstrLen1Byte = 8'h58;
  localparam logic [7:0] BstrLen2Byte = 8'h59;
  localparam logic [7:0] BstrShortLo  = 8'h40;
  localparam logic [7:0] BstrShortHi  = 8'h57;
  localparam logic [7:0] ShortLenMax  = 8'd23;

  // Fixed sizes of the envelope
  localparam logic [15:0] SigBytes    = 16'd64;
  localparam logic [15:0] ProtBytes   = 16'd13;
  localparam logic [15:0] PrefixBytes = 16'd5;
  localparam logic [15:0] ContentMax  = 16'd4096;
  localparam int unsigned ObjectMin   = 86;

  typedef enum logic [2:0] {
    ST_TAG    = 3'd0,
    ST_ARRAY  = 3'd1,
    ST_PROT   = 3'd2,
    ST_UNPROT = 3'd3,
    ST_PAY    = 3'd4,
    ST_SIG    = 3'd5,
    ST_END    = 3'd6,
    ST_FAIL   = 3'd7
  } stage_e;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_LEN1   = 3'd1,
    PH_LEN2HI = 3'd2,
    PH_LEN2LO = 3'd3,
    PH_BODY   = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_SIZE      = 4'd1,
    ERR_TAG       = 4'd2,
    ERR_ARRAY     = 4'd3,
    ERR_PROT_HDR  = 4'd4,
    ERR_PROT_SHP  = 4'd5,
    ERR_UNPROT    = 4'd6,
    ERR_PAY_HDR   = 4'd7,
    ERR_PAY_BOUND = 4'd8,
    ERR_SIG_HDR   = 4'd9,
    ERR_SIG_TRAIL = 4'd10
  } err_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_PAY   = 2'd1,
    KIND_SIG   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       byte_kind;
    logic [7:0]  out_byte;
    logic        done_res;
    err_e        error_code;
    logic [63:0] root_identifier;
    logic [12:0] payload_length;
  } result_t;

  // Expected leading bytes of the protected header string
  function automatic logic [7:0] prot_prefix(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'hA2;
      3'd1:    val = 8'h01;
      3'd2:    val = 8'h28;
      3'd3:    val = 8'h04;
      3'd4:    val = 8'h48;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sesp_core.sv -----
// ----------------------------------------------------------------------------
// sesp_core
// Parser state and the per-byte update: byte-string reader, stage checks,
// first-error latch, object size count and the verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sesp_core #(
  parameter int unsigned OBJECT_MAX = 4183
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output sesp_pkg::result_t      res_o
);
  import sesp_pkg::*;

  // Count saturates at OBJECT_MAX + 1
  localparam int unsigned CntW = $clog2(OBJECT_MAX + 2);
  localparam logic [CntW-1:0] ObjMax = CntW'(OBJECT_MAX);
  localparam logic [CntW-1:0] ObjMin = CntW'(ObjectMin);

  stage_e          stage_q, stage_d;
  phase_e          phase_q, phase_d;
  logic [15:0]     offset_q, offset_d;
  logic [15:0]     slen_q, slen_d;
  logic [CntW-1:0] count_q, count_d;
  logic [63:0]     kid_q, kid_d;
  err_e            ferr_q, ferr_d;
  logic            shape_q, shape_d;
  logic [12:0]     plen_q, plen_d;

  // Byte-string reader outputs
  phase_e          bs_phase;
  logic [15:0]     bs_len;
  logic [15:0]     bs_off;
  logic            bs_bad, bs_body, bs_done;

  logic            fail;
  err_e            fail_code;
  err_e            err;

  // Byte-string header / body reader
  always_comb begin
    bs_phase = phase_q;
    bs_len   = slen_q;
    bs_off   = offset_q;
    bs_bad   = 1'b0;
    bs_body  = 1'b0;
    bs_done  = 1'b0;
    case (phase_q)
      PH_HEAD: begin
        if (data_byte_i >= BstrShortLo && data_byte_i <= BstrShortHi) begin
          bs_len = {11'd0, data_byte_i[4:0]};
          bs_off = '0;
          if (data_byte_i[4:0] == 5'd0) begin
            bs_done = 1'b1;
          end else begin
            bs_phase = PH_BODY;
          end
        end else if (data_byte_i == BstrLen1Byte) begin
          bs_phase = PH_LEN1;
        end else if (data_byte_i == BstrLen2Byte) begin
          bs_phase = PH_LEN2HI;
        end else begin
          bs_bad = 1'b1;
        end
      end
      PH_LEN1: begin
        if (data_byte_i <= ShortLenMax) begin
          bs_bad = 1'b1;
        end else begin
          bs_len   = {8'd0, data_byte_i};
          bs_off   = '0;
          bs_phase = PH_BODY;
        end
      end
      PH_LEN2HI: begin
        bs_len   = {data_byte_i, 8'd0};
        bs_phase = PH_LEN2LO;
      end
      PH_LEN2LO: begin
        bs_len = {slen_q[15:8], data_byte_i};
        // non-minimal two-byte length
        if (slen_q[15:8] == 8'd0) begin
          bs_bad = 1'b1;
        end else begin
          bs_off   = '0;
          bs_phase = PH_BODY;
        end
      end
      default: begin
        bs_off  = offset_q + 16'd1;
        bs_body = 1'b1;
        bs_done = (bs_off == slen_q);
      end
    endcase
  end

  // Stage update and verdict
  always_comb begin
    stage_d   = stage_q;
    phase_d   = phase_q;
    offset_d  = offset_q;
    slen_d    = slen_q;
    kid_d     = kid_q;
    ferr_d    = ferr_q;
    shape_d   = shape_q;
    plen_d    = plen_q;
    fail      = 1'b0;
    fail_code = ERR_OK;
    err       = ERR_OK;
    res_o     = '0;

    count_d = (count_q <= ObjMax) ? count_q + 1'b1 : count_q;

    case (stage_q)
      ST_TAG: begin
        if (data_byte_i == TagByte) stage_d = ST_ARRAY;
        else begin fail = 1'b1; fail_code = ERR_TAG; end
      end
      ST_ARRAY: begin
        if (data_byte_i == ArrayByte) stage_d = ST_PROT;
        else begin fail = 1'b1; fail_code = ERR_ARRAY; end
      end
      ST_PROT: begin
        phase_d  = bs_phase;
        slen_d   = bs_len;
        offset_d = bs_off;
        if (bs_bad) begin
          fail = 1'b1; fail_code = ERR_PROT_HDR;
        end else begin
          if (bs_body) begin
            if (offset_q < PrefixBytes) begin
              if (data_byte_i != prot_prefix(offset_q[2:0])) shape_d = 1'b1;
            end else if (offset_q < ProtBytes) begin
              kid_d = {kid_q[55:0], data_byte_i};
            end
          end
          if (bs_done) begin
            phase_d = PH_HEAD;
            if (bs_len != ProtBytes || shape_d) begin
              fail = 1'b1; fail_code = ERR_PROT_SHP;
            end else begin
              stage_d = ST_UNPROT;
            end
          end
        end
      end
      ST_UNPROT: begin
        if (data_byte_i == EmptyMapByte) stage_d = ST_PAY;
        else begin fail = 1'b1; fail_code = ERR_UNPROT; end
      end
      ST_PAY: begin
        phase_d  = bs_phase;
        slen_d   = bs_len;
        offset_d = bs_off;
        if (bs_bad) begin
          fail = 1'b1; fail_code = ERR_PAY_HDR;
        end else begin
          if (bs_body) res_o.byte_kind = KIND_PAY;
          if (bs_done) begin
            phase_d = PH_HEAD;
            if (bs_len == 16'd0 || bs_len > ContentMax) begin
              fail = 1'b1; fail_code = ERR_PAY_BOUND;
            end else begin
              plen_d  = bs_len[12:0];
              stage_d = ST_SIG;
            end
          end
        end
      end
      ST_SIG: begin
        phase_d  = bs_phase;
        slen_d   = bs_len;
        offset_d = bs_off;
        if (bs_bad) begin
          fail = 1'b1; fail_code = ERR_SIG_HDR;
        end else begin
          if (bs_body) res_o.byte_kind = KIND_SIG;
          if (bs_done) begin
            phase_d = PH_HEAD;
            if (bs_len != SigBytes) begin
              fail = 1'b1; fail_code = ERR_SIG_TRAIL;
            end else begin
              stage_d = ST_END;
            end
          end
        end
      end
      ST_END: begin
        fail = 1'b1; fail_code = ERR_SIG_TRAIL;
      end
      default: ;
    endcase

    // First error wins; the rest of the object is ignored
    if (fail) begin
      if (ferr_q == ERR_OK) ferr_d = fail_code;
      stage_d = ST_FAIL;
    end

    if (res_o.byte_kind != KIND_FRAME) res_o.out_byte = data_byte_i;

    // Verdict on the last byte; size error outranks everything
    if (last_byte_i) begin
      if (count_d < ObjMin || count_d > ObjMax) begin
        err = ERR_SIZE;
      end else if (ferr_d != ERR_OK) begin
        err = ferr_d;
      end else begin
        case (stage_d)
          ST_TAG:    err = ERR_TAG;
          ST_ARRAY:  err = ERR_ARRAY;
          ST_PROT:   err = ERR_PROT_HDR;
          ST_UNPROT: err = ERR_UNPROT;
          ST_PAY:    err = ERR_PAY_HDR;
          ST_SIG:    err = ERR_SIG_HDR;
          default:   err = ERR_OK;
        endcase
      end
      res_o.done_res   = 1'b1;
      res_o.error_code = err;
      if (err == ERR_OK) begin
        res_o.root_identifier = kid_d;
        res_o.payload_length  = plen_d;
      end
      // back to reset for the next object
      stage_d  = ST_TAG;
      phase_d  = PH_HEAD;
      offset_d = '0;
      slen_d   = '0;
      count_d  = '0;
      kid_d    = '0;
      ferr_d   = ERR_OK;
      shape_d  = 1'b0;
      plen_d   = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ST_TAG;
      phase_q  <= PH_HEAD;
      offset_q <= '0;
      slen_q   <= '0;
      count_q  <= '0;
      kid_q    <= '0;
      ferr_q   <= ERR_OK;
      shape_q  <= 1'b0;
      plen_q   <= '0;
    end else if (step_i) begin
      stage_q  <= stage_d;
      phase_q  <= phase_d;
      offset_q <= offset_d;
      slen_q   <= slen_d;
      count_q  <= count_d;
      kid_q    <= kid_d;
      ferr_q   <= ferr_d;
      shape_q  <= shape_d;
      plen_q   <= plen_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/signed_envelope_stream_parser.sv -----
// ----------------------------------------------------------------------------
// signed_envelope_stream_parser
// Byte-serial checker for a signed envelope object with payload/signature
// forwarding and a verdict on the last byte.
// ----------------------------------------------------------------------------
// Takes one object byte per cycle while out_ready_i does not stall the output
// and returns one result per byte. A byte is captured in an input register,
// the parser state is updated from that register and the result lands in an
// output register; the sustained rate of one byte per clock is limited only by
// back-pressure on out_ready_i. Payload bytes come out with byte_kind 1 and
// signature bytes with byte_kind 2; the last byte carries done_res, the
// error code and, when the code is zero, the root id and payload length.
// Bytes already forwarded must be dropped if the verdict is an error.
`default_nettype none

module signed_envelope_stream_parser #(
  parameter int unsigned OBJECT_MAX = 4183
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       byte_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             done_res_o,
  output logic [3:0]       error_code_o,
  output logic [63:0]      root_identifier_o,
  output logic [12:0]      payload_length_o
);
  import sesp_pkg::*;

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_v_q;
  result_t    res_q;
  result_t    res_d;
  logic       advance;
  logic       step;

  // Pipeline control: a request moves when the next stage is free
  assign advance    = !out_v_q || out_ready_i;
  assign step       = in_v_q && advance;
  assign in_ready_o = !in_v_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  sesp_core #(
    .OBJECT_MAX (OBJECT_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .res_o       (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign byte_kind_o       = res_q.byte_kind;
  assign out_byte_o        = res_q.out_byte;
  assign done_res_o        = res_q.done_res;
  assign error_code_o      = res_q.error_code;
  assign root_identifier_o = res_q.root_identifier;
  assign payload_length_o  = res_q.payload_length;

endmodule

`default_nettype wire
